>>> sv/assert_macros.svh
// Assertion macros shared by the decoder RTL.
// Expects clk and rst_n in the scope of every use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs during reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/utfdec_pkg.sv
// Types and constants for the UTF codepoint decoder.
// No dependencies; used by the core, the result queue and the top level.
package utfdec_pkg;

  typedef enum logic [1:0] {
    ENC_OCTET   = 2'd0,
    ENC_UTF8    = 2'd1,
    ENC_UTF16BE = 2'd2,
    ENC_UTF16LE = 2'd3
  } enc_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BAD   = 2'd1,
    ST_TRUNC = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  localparam logic [20:0] MAX_CP     = 21'h10FFFF;
  localparam logic [20:0] SUPP_BASE  = 21'h010000;
  localparam logic [5:0]  HIGH_TAG   = 6'b110110;  // 0xD800 under mask 0xFC00
  localparam logic [5:0]  LOW_TAG    = 6'b110111;  // 0xDC00 under mask 0xFC00
  localparam enc_t        ENC_RESET  = ENC_UTF8;

  typedef struct packed {
    logic [20:0] cp;
    status_t     st;
    logic        last;
  } res_t;

  // Results from one accepted byte, oldest in r0.
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

>>> sv/utfdec_core.sv
// Decode core: sequence state registers and the per-byte decode logic.
// Depends on utfdec_pkg; pushes up to two results per byte into the queue.
`include "assert_macros.svh"

module utfdec_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_wdata,
  input  logic                 in_fire,
  input  logic [7:0]           in_byte,
  input  logic                 in_last,
  output utfdec_pkg::push_t    push
);

  utfdec_pkg::enc_t enc_r;
  logic [20:0] code_accum_r, code_accum_nxt;
  logic [1:0]  bytes_left_r, bytes_left_nxt;
  logic        half_valid_r, half_valid_nxt;
  logic [7:0]  half_byte_r, half_byte_nxt;
  logic        high_pend_r, high_pend_nxt;
  logic [9:0]  high_bits_r, high_bits_nxt;

  logic [1:0]        n;
  utfdec_pkg::res_t  r0, r1;
  logic [15:0]       unit;
  logic [20:0]       acc_shift;
  logic [20:0]       high_cp;
  logic [20:0]       pair_cp;

  always_comb begin
    unit      = (enc_r == utfdec_pkg::ENC_UTF16LE) ? {in_byte, half_byte_r}
                                                   : {half_byte_r, in_byte};
    acc_shift = {code_accum_r[14:0], in_byte[5:0]};
    high_cp   = {5'd0, utfdec_pkg::HIGH_TAG, high_bits_r};
    pair_cp   = {1'b0, high_bits_r, unit[9:0]} + utfdec_pkg::SUPP_BASE;

    code_accum_nxt = code_accum_r;
    bytes_left_nxt = bytes_left_r;
    half_valid_nxt = half_valid_r;
    half_byte_nxt  = half_byte_r;
    high_pend_nxt  = high_pend_r;
    high_bits_nxt  = high_bits_r;
    n  = 2'd0;
    r0 = '{cp: 21'd0, st: utfdec_pkg::ST_OK, last: 1'b0};
    r1 = '{cp: 21'd0, st: utfdec_pkg::ST_OK, last: 1'b0};

    case (enc_r)
      utfdec_pkg::ENC_OCTET: begin
        n = 2'd1;
        r0.cp = {13'd0, in_byte};
      end
      utfdec_pkg::ENC_UTF8: begin
        if (bytes_left_r == 2'd0) begin
          n = 2'd1;
          if (!in_byte[7]) begin
            r0.cp = {13'd0, in_byte};
          end else if (in_byte[7:5] == 3'b110 || in_byte[7:4] == 4'b1110 ||
                       in_byte[7:3] == 5'b11110) begin
            if (in_last) begin
              r0.st = utfdec_pkg::ST_TRUNC;
            end else begin
              n = 2'd0;
              if (in_byte[7:5] == 3'b110) begin
                code_accum_nxt = {16'd0, in_byte[4:0]};
                bytes_left_nxt = 2'd1;
              end else if (in_byte[7:4] == 4'b1110) begin
                code_accum_nxt = {17'd0, in_byte[3:0]};
                bytes_left_nxt = 2'd2;
              end else begin
                code_accum_nxt = {18'd0, in_byte[2:0]};
                bytes_left_nxt = 2'd3;
              end
            end
          end else begin
            r0.st = utfdec_pkg::ST_BAD;
          end
        end else if (in_last && bytes_left_r > 2'd1) begin
          n = 2'd1;
          r0.st = utfdec_pkg::ST_TRUNC;
          bytes_left_nxt = 2'd0;
        end else if (in_byte[7:6] != 2'b10) begin
          // bad continuation is consumed, not retried as a lead
          n = 2'd1;
          r0.st = utfdec_pkg::ST_BAD;
          bytes_left_nxt = 2'd0;
        end else begin
          code_accum_nxt = acc_shift;
          bytes_left_nxt = bytes_left_r - 2'd1;
          if (bytes_left_r == 2'd1) begin
            n = 2'd1;
            if (acc_shift > utfdec_pkg::MAX_CP) begin
              r0.st = utfdec_pkg::ST_BAD;
            end else begin
              r0.cp = acc_shift;
            end
          end
        end
      end
      default: begin
        if (!half_valid_r) begin
          if (in_last) begin
            if (high_pend_r) begin
              n = 2'd2;
              r0.cp = high_cp;
              r1.st = utfdec_pkg::ST_TRUNC;
            end else begin
              n = 2'd1;
              r0.st = utfdec_pkg::ST_TRUNC;
            end
          end else begin
            half_valid_nxt = 1'b1;
            half_byte_nxt  = in_byte;
          end
        end else begin
          half_valid_nxt = 1'b0;
          if (high_pend_r && unit[15:10] == utfdec_pkg::LOW_TAG) begin
            n = 2'd1;
            r0.cp = pair_cp;
            high_pend_nxt = 1'b0;
          end else if (unit[15:10] == utfdec_pkg::HIGH_TAG && !in_last) begin
            // new high surrogate is held; a held one is flushed first
            high_pend_nxt = 1'b1;
            high_bits_nxt = unit[9:0];
            if (high_pend_r) begin
              n = 2'd1;
              r0.cp = high_cp;
            end
          end else begin
            high_pend_nxt = 1'b0;
            if (high_pend_r) begin
              n = 2'd2;
              r0.cp = high_cp;
              r1.cp = {5'd0, unit};
            end else begin
              n = 2'd1;
              r0.cp = {5'd0, unit};
            end
          end
        end
      end
    endcase

    if (n == 2'd2) begin
      r1.last = 1'b1;
    end else begin
      r0.last = 1'b1;
    end

    if (in_last) begin
      bytes_left_nxt = 2'd0;
      half_valid_nxt = 1'b0;
      high_pend_nxt  = 1'b0;
    end

    push.n  = in_fire ? n : 2'd0;
    push.r0 = r0;
    push.r1 = r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enc_r        <= utfdec_pkg::ENC_RESET;
      bytes_left_r <= 2'd0;
      half_valid_r <= 1'b0;
      high_pend_r  <= 1'b0;
    end else if (cfg_we) begin
      enc_r        <= utfdec_pkg::enc_t'(cfg_wdata);
      bytes_left_r <= 2'd0;
      half_valid_r <= 1'b0;
      high_pend_r  <= 1'b0;
    end else if (in_fire) begin
      bytes_left_r <= bytes_left_nxt;
      half_valid_r <= half_valid_nxt;
      high_pend_r  <= high_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      code_accum_r <= code_accum_nxt;
      half_byte_r  <= half_byte_nxt;
      high_bits_r  <= high_bits_nxt;
    end
  end

  `ASSERT_CLK(a_utf8_state_only_utf8,
    (bytes_left_r != 2'd0) |-> (enc_r == utfdec_pkg::ENC_UTF8),
    "UTF-8 sequence state outside UTF-8 mode")
  `ASSERT_CLK(a_utf16_state_only_utf16,
    (half_valid_r || high_pend_r) |->
      (enc_r == utfdec_pkg::ENC_UTF16BE || enc_r == utfdec_pkg::ENC_UTF16LE),
    "UTF-16 sequence state outside UTF-16 mode")
  `ASSERT_CLK(a_err_zero_cp,
    (push.n != 2'd0 && push.r0.st != utfdec_pkg::ST_OK) |-> (push.r0.cp == 21'd0),
    "error result carries a nonzero codepoint")
  `ASSERT_CLK(a_last_clears,
    (in_fire && in_last && !cfg_we) |=>
      (bytes_left_r == 2'd0 && !half_valid_r && !high_pend_r),
    "sequence state survives end of string")

endmodule

>>> sv/utfdec_rq.sv
// Result queue: three-entry ring that takes up to two results per cycle.
// Depends on utfdec_pkg; drives the master-side stream of the decoder.
`include "assert_macros.svh"

module utfdec_rq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  utfdec_pkg::push_t    push,
  output logic                 can_take,
  output logic                 out_valid,
  input  logic                 out_ready,
  output utfdec_pkg::res_t     out_res
);

  localparam int DEPTH = 3;

  utfdec_pkg::res_t ent_r [DEPTH];
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;
  logic [1:0] wr_ptr_p1;

  function automatic logic [1:0] ptr_inc(input logic [1:0] p);
    return (p == 2'(DEPTH - 1)) ? 2'd0 : p + 2'd1;
  endfunction

  always_comb begin
    pop        = out_valid && out_ready;
    wr_ptr_p1  = ptr_inc(wr_ptr_r);
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    case (push.n)
      2'd1:    wr_ptr_nxt = wr_ptr_p1;
      2'd2:    wr_ptr_nxt = ptr_inc(wr_ptr_p1);
      default: wr_ptr_nxt = wr_ptr_r;
    endcase
    cnt_nxt = cnt_r + push.n - {1'b0, pop};
  end

  // room for two more results regardless of the drain side
  assign can_take  = (cnt_r <= 2'd1);
  assign out_valid = (cnt_r != 2'd0);
  assign out_res   = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 2'd0;
      wr_ptr_r <= 2'd0;
      cnt_r    <= 2'd0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (push.n != 2'd0 && wr_ptr_r == 2'(i)) begin
        ent_r[i] <= push.r0;
      end else if (push.n == 2'd2 && wr_ptr_p1 == 2'(i)) begin
        ent_r[i] <= push.r1;
      end
    end
  end

  `ASSERT_CLK(a_push_has_room,
    (push.n != 2'd0) |-> (cnt_r <= 2'd1),
    "result pushed into a full queue")
  `ASSERT_CLK(a_count_tracks,
    1'b1 |=> (cnt_r == $past(cnt_r) + $past(push.n) - {1'b0, $past(pop)}),
    "queue count does not track pushes and pops")
  `ASSERT_CLK(a_drain_empties,
    (cnt_r == 2'd1 && pop && push.n == 2'd0) |=> !out_valid,
    "queue still valid after last entry was taken")

endmodule

>>> sv/utf_codepoint_decoder.sv
// Top level of the UTF codepoint decoder: stream ports, config register port.
// Depends on utfdec_pkg, utfdec_core and utfdec_rq.
//
// Takes one byte per clock and decodes it into Unicode codepoints under the
// encoding register (0 raw octets, 1 UTF-8, 2 UTF-16 BE, 3 UTF-16 LE, reset
// UTF-8). Each byte yields zero, one or two results; out_tlast marks the last
// result caused by a byte, out_tuser carries the status (0 ok, 1 invalid or
// out of range, 2 truncated), and the codepoint is zero on any error. Decode
// finishes in the cycle a byte is accepted and the result is written into the
// result queue behind any waiting entries. Sustained rate is one byte per cycle
// with the output always ready; a byte producing two results (an unpaired
// UTF-16 high surrogate flushed ahead of the next unit) holds off the next byte,
// since the single output port drains a three-entry result queue one entry per cycle.
// Writing cfg_wdata through cfg_we clears any partial sequence; write only
// while the stream is idle.
module utf_codepoint_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [20:0] codepoint, [23:21] zero
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic        out_tlast   // last_of_run
);

  utfdec_pkg::push_t push;
  utfdec_pkg::res_t  out_res;
  logic              in_fire;

  assign in_fire = in_tvalid && in_tready;

  utfdec_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_fire   (in_fire),
    .in_byte   (in_tdata),
    .in_last   (in_tlast),
    .push      (push)
  );

  utfdec_rq u_rq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .can_take  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {3'd0, out_res.cp};
  assign out_tuser = out_res.st;
  assign out_tlast = out_res.last;

endmodule
